FILE: hw/rtl/udp_seq_loss_jitter_tracker_defines.svh
// Assertion macros shared by the packet statistics RTL.
`ifndef UDP_SEQ_LOSS_JITTER_TRACKER_DEFINES_SVH
`define UDP_SEQ_LOSS_JITTER_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define USLJT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define USLJT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/usljt_pkg.sv
// Package: widths, constants and item types of the packet statistics block.
package usljt_pkg;

    localparam int SEQ_WIDTH   = 32;
    localparam int USEC_WIDTH  = 20;
    localparam int SEC_WIDTH   = 32;
    localparam int BYTES_WIDTH = 16;
    localparam int CNT_WIDTH   = 32;
    localparam int WIDE_WIDTH  = 48;
    localparam int TRAN_WIDTH  = 64;
    // seconds * 1e6 + microseconds stays below 2^53
    localparam int TIME_WIDTH  = 53;

    localparam logic [USEC_WIDTH-1:0] USEC_PER_SEC = USEC_WIDTH'(1000000);
    localparam logic [WIDE_WIDTH:0]   JITTER_ROUND = (WIDE_WIDTH+1)'(8);
    localparam int                    JITTER_SHIFT = 4;

    typedef struct packed {
        logic [SEC_WIDTH-1:0]   send_seconds;
        logic [USEC_WIDTH-1:0]  send_microseconds;
        logic [CNT_WIDTH-1:0]   sequence_number;
        logic [SEC_WIDTH-1:0]   recv_seconds;
        logic [USEC_WIDTH-1:0]  recv_microseconds;
        logic [BYTES_WIDTH-1:0] byte_count;
    } pkt_item_t;

    typedef struct packed {
        logic [SEQ_WIDTH-1:0]          seq;
        logic [BYTES_WIDTH-1:0]        byte_count;
        logic signed [TRAN_WIDTH-1:0]  transit_us;
    } transit_item_t;

    typedef struct packed {
        logic [CNT_WIDTH-1:0]          highest_sequence;
        logic [CNT_WIDTH-1:0]          lost_packets;
        logic [CNT_WIDTH-1:0]          out_of_order_packets;
        logic [WIDE_WIDTH-1:0]         jitter_q4;
        logic signed [TRAN_WIDTH-1:0]  transit_us;
        logic [CNT_WIDTH-1:0]          packets_received;
        logic [WIDE_WIDTH-1:0]         bytes_received;
    } stats_item_t;

endpackage

FILE: hw/rtl/usljt_pkt_if.sv
// Interface: packet item channel (valid/ready plus packet fields).
interface usljt_pkt_if;
    logic                                  valid;
    logic                                  ready;
    logic [usljt_pkg::SEC_WIDTH-1:0]       send_seconds;
    logic [usljt_pkg::USEC_WIDTH-1:0]      send_microseconds;
    logic [usljt_pkg::CNT_WIDTH-1:0]       sequence_number;
    logic [usljt_pkg::SEC_WIDTH-1:0]       recv_seconds;
    logic [usljt_pkg::USEC_WIDTH-1:0]      recv_microseconds;
    logic [usljt_pkg::BYTES_WIDTH-1:0]     byte_count;

    modport source (
        output valid, send_seconds, send_microseconds, sequence_number,
               recv_seconds, recv_microseconds, byte_count,
        input  ready
    );

    modport sink (
        input  valid, send_seconds, send_microseconds, sequence_number,
               recv_seconds, recv_microseconds, byte_count,
        output ready
    );
endinterface

FILE: hw/rtl/usljt_stats_if.sv
// Interface: statistics result channel (valid/ready plus running totals).
interface usljt_stats_if;
    logic                                  valid;
    logic                                  ready;
    logic [usljt_pkg::CNT_WIDTH-1:0]       highest_sequence;
    logic [usljt_pkg::CNT_WIDTH-1:0]       lost_packets;
    logic [usljt_pkg::CNT_WIDTH-1:0]       out_of_order_packets;
    logic [usljt_pkg::WIDE_WIDTH-1:0]      jitter_q4;
    logic signed [usljt_pkg::TRAN_WIDTH-1:0] transit_us;
    logic [usljt_pkg::CNT_WIDTH-1:0]       packets_received;
    logic [usljt_pkg::WIDE_WIDTH-1:0]      bytes_received;

    modport source (
        output valid, highest_sequence, lost_packets, out_of_order_packets,
               jitter_q4, transit_us, packets_received, bytes_received,
        input  ready
    );

    modport sink (
        input  valid, highest_sequence, lost_packets, out_of_order_packets,
               jitter_q4, transit_us, packets_received, bytes_received,
        output ready
    );
endinterface

FILE: hw/rtl/usljt_time_stage.sv
// Timestamp pipeline: input register, microsecond totals, transit time.
module usljt_time_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  usljt_pkg::pkt_item_t      in_item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output usljt_pkg::transit_item_t  out_item
);

    localparam int TW = usljt_pkg::TIME_WIDTH;

    logic                                s0_valid_reg;
    logic                                s0_valid_next;
    usljt_pkg::pkt_item_t                s0_item_reg;

    logic                                s1_valid_reg;
    logic                                s1_valid_next;
    logic [TW-1:0]                       s1_recv_reg;
    logic [TW-1:0]                       s1_send_reg;
    logic [usljt_pkg::SEQ_WIDTH-1:0]     s1_seq_reg;
    logic [usljt_pkg::BYTES_WIDTH-1:0]   s1_bytes_reg;

    logic                                s2_valid_reg;
    logic                                s2_valid_next;
    usljt_pkg::transit_item_t            s2_item_reg;

    logic                                s0_ready;
    logic                                s1_ready;
    logic                                s2_ready;
    logic [TW-1:0]                       recv_total;
    logic [TW-1:0]                       send_total;
    logic signed [usljt_pkg::TRAN_WIDTH-1:0] transit;

    // a stage takes a new item when empty or when its item moves on
    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s0_ready = !s0_valid_reg || s1_ready;
    assign in_ready = s0_ready;

    assign s0_valid_next = s0_ready ? in_valid     : s0_valid_reg;
    assign s1_valid_next = s1_ready ? s0_valid_reg : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    // constant multiply by one million, one per timestamp
    assign recv_total = TW'(s0_item_reg.recv_seconds) * TW'(usljt_pkg::USEC_PER_SEC)
                      + TW'(s0_item_reg.recv_microseconds);
    assign send_total = TW'(s0_item_reg.send_seconds) * TW'(usljt_pkg::USEC_PER_SEC)
                      + TW'(s0_item_reg.send_microseconds);

    assign transit = $signed(usljt_pkg::TRAN_WIDTH'(s1_recv_reg))
                   - $signed(usljt_pkg::TRAN_WIDTH'(s1_send_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && in_valid)
        begin
            s0_item_reg <= in_item;
        end
        if (s1_ready && s0_valid_reg)
        begin
            s1_recv_reg  <= recv_total;
            s1_send_reg  <= send_total;
            s1_seq_reg   <= s0_item_reg.sequence_number[usljt_pkg::SEQ_WIDTH-1:0];
            s1_bytes_reg <= s0_item_reg.byte_count;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_item_reg.seq        <= s1_seq_reg;
            s2_item_reg.byte_count <= s1_bytes_reg;
            s2_item_reg.transit_us <= transit;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;

endmodule

FILE: hw/rtl/usljt_stats_update.sv
// Statistics update: sequence, loss, reorder, jitter and totals, result register.
`include "udp_seq_loss_jitter_tracker_defines.svh"

module usljt_stats_update (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  usljt_pkg::transit_item_t  in_item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output usljt_pkg::stats_item_t    out_item
);

    localparam int SW = usljt_pkg::SEQ_WIDTH;
    localparam int CW = usljt_pkg::CNT_WIDTH;
    localparam int WW = usljt_pkg::WIDE_WIDTH;
    localparam int TRW = usljt_pkg::TRAN_WIDTH;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [SW-1:0]         seq_high_reg;
    logic [SW-1:0]         seq_high_next;
    logic [CW-1:0]         loss_total_reg;
    logic [CW-1:0]         loss_total_next;
    logic [CW-1:0]         reorder_total_reg;
    logic [CW-1:0]         reorder_total_next;
    logic [TRW-1:0]        last_transit_reg;
    logic [TRW-1:0]        last_transit_next;
    logic [WW-1:0]         jitter_acc_reg;
    logic [WW-1:0]         jitter_acc_next;
    logic [CW-1:0]         packet_total_reg;
    logic [CW-1:0]         packet_total_next;
    logic [WW-1:0]         byte_total_reg;
    logic [WW-1:0]         byte_total_next;

    logic                  upd_fire;
    logic                  fwd;
    logic [SW-1:0]         gap;
    logic [CW:0]           loss_sum;
    logic [WW:0]           byte_sum;
    logic [TRW-1:0]        diff_pos;
    logic [TRW-1:0]        diff_neg;
    logic [TRW-1:0]        mag;
    logic [WW:0]           jitter_rnd;
    logic [WW-1:0]         jitter_base;
    logic [TRW:0]          jitter_sum;

    assign in_ready = !out_valid_reg || out_ready;
    assign upd_fire = in_valid && in_ready;
    assign out_valid_next = in_ready ? in_valid : out_valid_reg;

    assign fwd      = in_item.seq > seq_high_reg;
    assign gap      = in_item.seq - seq_high_reg - SW'(1);
    assign loss_sum = (CW+1)'(loss_total_reg) + (CW+1)'(gap);
    assign byte_sum = (WW+1)'(byte_total_reg) + (WW+1)'(in_item.byte_count);

    // both signs of the difference in parallel, pick by sign
    assign diff_pos = TRW'(in_item.transit_us) - last_transit_reg;
    assign diff_neg = last_transit_reg - TRW'(in_item.transit_us);
    assign mag      = diff_pos[TRW-1] ? diff_neg : diff_pos;

    // J - round(J/16) depends on state only and never goes below zero
    assign jitter_rnd  = ((WW+1)'(jitter_acc_reg) + usljt_pkg::JITTER_ROUND)
                         >> usljt_pkg::JITTER_SHIFT;
    assign jitter_base = jitter_acc_reg - WW'(jitter_rnd);
    assign jitter_sum  = (TRW+1)'(mag) + (TRW+1)'(jitter_base);

    always_comb
    begin
        seq_high_next      = seq_high_reg;
        loss_total_next    = loss_total_reg;
        reorder_total_next = reorder_total_reg;
        last_transit_next  = last_transit_reg;
        jitter_acc_next    = jitter_acc_reg;
        packet_total_next  = packet_total_reg;
        byte_total_next    = byte_total_reg;

        if (upd_fire)
        begin
            packet_total_next = (packet_total_reg == '1) ? packet_total_reg
                                                         : packet_total_reg + CW'(1);
            byte_total_next   = byte_sum[WW] ? '1 : byte_sum[WW-1:0];

            if (fwd)
            begin
                seq_high_next   = in_item.seq;
                loss_total_next = loss_sum[CW] ? '1 : loss_sum[CW-1:0];
            end
            else
            begin
                reorder_total_next = (reorder_total_reg == '1) ? reorder_total_reg
                                                               : reorder_total_reg + CW'(1);
                if (loss_total_reg != '0)
                begin
                    loss_total_next = loss_total_reg - CW'(1);
                end
            end

            last_transit_next = TRW'(in_item.transit_us);
            jitter_acc_next   = (|jitter_sum[TRW:WW]) ? '1 : jitter_sum[WW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            seq_high_reg      <= '0;
            loss_total_reg    <= '0;
            reorder_total_reg <= '0;
            last_transit_reg  <= '0;
            jitter_acc_reg    <= '0;
            packet_total_reg  <= '0;
            byte_total_reg    <= '0;
        end
        else
        begin
            out_valid_reg     <= out_valid_next;
            seq_high_reg      <= seq_high_next;
            loss_total_reg    <= loss_total_next;
            reorder_total_reg <= reorder_total_next;
            last_transit_reg  <= last_transit_next;
            jitter_acc_reg    <= jitter_acc_next;
            packet_total_reg  <= packet_total_next;
            byte_total_reg    <= byte_total_next;
        end
    end

    // the state registers are the result register
    always_comb
    begin
        out_item.highest_sequence     = CW'(seq_high_reg);
        out_item.lost_packets         = loss_total_reg;
        out_item.out_of_order_packets = reorder_total_reg;
        out_item.jitter_q4            = jitter_acc_reg;
        out_item.transit_us           = $signed(last_transit_reg);
        out_item.packets_received     = packet_total_reg;
        out_item.bytes_received       = byte_total_reg;
    end

    assign out_valid = out_valid_reg;

    `USLJT_ASSERT_NXT(a_pkt_count_moves, upd_fire,
        packet_total_reg != $past(packet_total_reg) || packet_total_reg == '1,
        "packet count did not advance on an item")
    `USLJT_ASSERT_NXT(a_fwd_takes_seq, upd_fire && fwd,
        seq_high_reg == $past(in_item.seq),
        "forward packet did not become highest sequence")
    `USLJT_ASSERT_NXT(a_reorder_no_loss_rise, upd_fire && !fwd,
        loss_total_reg <= $past(loss_total_reg) && seq_high_reg == $past(seq_high_reg),
        "non-advancing packet raised loss or moved highest sequence")

endmodule

FILE: hw/rtl/udp_seq_loss_jitter_tracker.sv
// Top level: receive-side sequence loss, reorder and jitter statistics.
//
// Channel packet (sink) carries one item per received test packet: sender
// and receiver timestamps (seconds plus microseconds), sequence number and
// byte count. Channel report (source) returns one item per packet with the
// running totals after that packet: highest sequence, estimated losses,
// out-of-order count, Q4 interarrival jitter, this packet's transit time,
// packet count and byte count. Counters saturate at their maxima.
//
// From acceptance to report valid an item passes four register stages:
// input register, microsecond totals (one constant multiply per timestamp),
// transit subtract, then the statistics update, whose state registers are
// the report register. Throughput is one item per cycle unless report
// stalls; the state loop from one item to the next is the update stage.
//
// Reset clears every total, the last transit time and all stage valids.
// When report is stalled, each stage holds its item; stages that are empty
// still take new items, so up to four items sit in flight before packet.ready
// drops.
module udp_seq_loss_jitter_tracker (
    input  logic           clk,
    input  logic           rst_n,
    usljt_pkt_if.sink      packet,
    usljt_stats_if.source  report
);

    usljt_pkg::pkt_item_t      pkt_item;
    logic                      tr_valid;
    logic                      tr_ready;
    usljt_pkg::transit_item_t  tr_item;
    usljt_pkg::stats_item_t    st_item;

    // gather the packet fields into one item
    always_comb
    begin
        pkt_item.send_seconds      = packet.send_seconds;
        pkt_item.send_microseconds = packet.send_microseconds;
        pkt_item.sequence_number   = packet.sequence_number;
        pkt_item.recv_seconds      = packet.recv_seconds;
        pkt_item.recv_microseconds = packet.recv_microseconds;
        pkt_item.byte_count        = packet.byte_count;
    end

    // timestamp arithmetic: three register stages ending in transit time
    usljt_time_stage u_time (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (packet.valid),
        .in_ready  (packet.ready),
        .in_item   (pkt_item),
        .out_valid (tr_valid),
        .out_ready (tr_ready),
        .out_item  (tr_item)
    );

    // per-packet statistics update; holds the report while stalled
    usljt_stats_update u_stats (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tr_valid),
        .in_ready  (tr_ready),
        .in_item   (tr_item),
        .out_valid (report.valid),
        .out_ready (report.ready),
        .out_item  (st_item)
    );

    // spread the result item onto the report fields
    always_comb
    begin
        report.highest_sequence     = st_item.highest_sequence;
        report.lost_packets         = st_item.lost_packets;
        report.out_of_order_packets = st_item.out_of_order_packets;
        report.jitter_q4            = st_item.jitter_q4;
        report.transit_us           = st_item.transit_us;
        report.packets_received     = st_item.packets_received;
        report.bytes_received       = st_item.bytes_received;
    end

endmodule

FILE: bench/usljt_stats_checker.sv
// Checker: watches both channels, predicts each statistics item and compares it.
module usljt_stats_checker
    import usljt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    usljt_pkt_if    pkt_mon,
    usljt_stats_if  stats_mon,
    output int      fail_count,
    output int      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] CNT_MAX  = (64'd1 << CNT_WIDTH) - 64'd1;
    localparam logic [63:0] WIDE_MAX = (64'd1 << WIDE_WIDTH) - 64'd1;
    localparam logic [63:0] USEC     = 64'(USEC_PER_SEC);

    // Predicted running state of the block.
    logic [63:0] top_seq;
    logic [63:0] loss_count;
    logic [63:0] reorder_count;
    logic [63:0] held_transit;
    logic [63:0] jitter_acc_q4;
    logic [63:0] pkt_count;
    logic [63:0] byte_sum;

    stats_item_t expected_stats[$];

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] max);
        if (b > max || a > max - b)
            return max;
        return a + b;
    endfunction

    function automatic stats_item_t predict_stats(input pkt_item_t p);
        logic [63:0] seq;
        logic [63:0] recv_us;
        logic [63:0] send_us;
        logic [63:0] transit;
        logic [63:0] diff;
        logic [63:0] mag;
        logic [63:0] jnext;
        stats_item_t r;

        seq = 64'(p.sequence_number[SEQ_WIDTH-1:0]);
        pkt_count = sat_add(pkt_count, 64'd1, CNT_MAX);
        byte_sum  = sat_add(byte_sum, 64'(p.byte_count), WIDE_MAX);

        if (seq > top_seq) begin
            if (seq > top_seq + 64'd1)
                loss_count = sat_add(loss_count, seq - top_seq - 64'd1, CNT_MAX);
            top_seq = seq;
        end
        else begin
            reorder_count = sat_add(reorder_count, 64'd1, CNT_MAX);
            if (loss_count != 64'd0)
                loss_count = loss_count - 64'd1;
        end

        // wraps to the two's complement of the signed difference
        recv_us = 64'(p.recv_seconds) * USEC + 64'(p.recv_microseconds);
        send_us = 64'(p.send_seconds) * USEC + 64'(p.send_microseconds);
        transit = recv_us - send_us;
        diff    = transit - held_transit;
        mag     = diff[63] ? (64'd0 - diff) : diff;
        held_transit = transit;

        jnext = jitter_acc_q4 + mag - ((jitter_acc_q4 + 64'(JITTER_ROUND)) >> JITTER_SHIFT);
        jitter_acc_q4 = (jnext > WIDE_MAX) ? WIDE_MAX : jnext;

        r.highest_sequence     = top_seq[CNT_WIDTH-1:0];
        r.lost_packets         = loss_count[CNT_WIDTH-1:0];
        r.out_of_order_packets = reorder_count[CNT_WIDTH-1:0];
        r.jitter_q4            = jitter_acc_q4[WIDE_WIDTH-1:0];
        r.transit_us           = transit;
        r.packets_received     = pkt_count[CNT_WIDTH-1:0];
        r.bytes_received       = byte_sum[WIDE_WIDTH-1:0];
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        pkt_item_t   p;
        stats_item_t e;

        if (!rst_n) begin
            top_seq       = '0;
            loss_count    = '0;
            reorder_count = '0;
            held_transit  = '0;
            jitter_acc_q4 = '0;
            pkt_count     = '0;
            byte_sum      = '0;
            expected_stats.delete();
            fail_count    = 0;
            pending       = 0;
        end
        else begin
            if (stats_mon.valid && stats_mon.ready) begin
                if (expected_stats.size() == 0) begin
                    $display("%0t: unexpected report item, expected none, actual transit %0h",
                             $time, stats_mon.transit_us);
                    fail_count++;
                end
                else begin
                    e = expected_stats.pop_front();
                    compare_field("highest_sequence", 64'(e.highest_sequence),
                                  64'(stats_mon.highest_sequence));
                    compare_field("lost_packets", 64'(e.lost_packets),
                                  64'(stats_mon.lost_packets));
                    compare_field("out_of_order_packets", 64'(e.out_of_order_packets),
                                  64'(stats_mon.out_of_order_packets));
                    compare_field("jitter_q4", 64'(e.jitter_q4), 64'(stats_mon.jitter_q4));
                    compare_field("transit_us", e.transit_us, stats_mon.transit_us);
                    compare_field("packets_received", 64'(e.packets_received),
                                  64'(stats_mon.packets_received));
                    compare_field("bytes_received", 64'(e.bytes_received),
                                  64'(stats_mon.bytes_received));
                end
            end
            if (pkt_mon.valid && pkt_mon.ready) begin
                p.send_seconds      = pkt_mon.send_seconds;
                p.send_microseconds = pkt_mon.send_microseconds;
                p.sequence_number   = pkt_mon.sequence_number;
                p.recv_seconds      = pkt_mon.recv_seconds;
                p.recv_microseconds = pkt_mon.recv_microseconds;
                p.byte_count        = pkt_mon.byte_count;
                expected_stats.push_back(predict_stats(p));
            end
            pending = expected_stats.size();
        end
    end

endmodule

FILE: bench/tb_udp_seq_loss_jitter_tracker.sv
// Testbench top: drives packet items, stalls the report side and gives the verdict.
module tb_udp_seq_loss_jitter_tracker;
    timeunit 1ns;
    timeprecision 1ps;
    import usljt_pkg::*;

    localparam int          RANDOM_ITEMS  = 400;
    localparam int          STREAM_LENGTH = 64;
    localparam logic [63:0] USEC          = 64'(USEC_PER_SEC);

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_LIGHT,
        SINK_HEAVY,
        SINK_LONG
    } sink_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    usljt_pkt_if   packet_ch ();
    usljt_stats_if report_ch ();

    int fail_count;
    int pending;

    // Generator state: highest sequence sent so far and the sender's clock.
    logic [31:0] front_seq;
    logic [63:0] send_clock;
    logic [63:0] base_delay;

    // Receiver stall pattern state.
    logic        sink_ready  = 1'b0;
    logic [31:0] stall_cycle = '0;
    int unsigned stall_hold  = 0;

    udp_seq_loss_jitter_tracker u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .packet (packet_ch),
        .report (report_ch)
    );

    usljt_stats_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt_mon    (packet_ch),
        .stats_mon  (report_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    assign report_ch.ready = sink_ready;

    // Cycle the receiver through four stall styles in turn: always ready,
    // rare stalls, coin-flip stalls, and long runs of stall or accept.
    always @(posedge clk)
    begin
        stall_cycle <= stall_cycle + 32'd1;
        case (sink_mode_t'(stall_cycle[8:7]))
            SINK_OPEN:  sink_ready <= 1'b1;
            SINK_LIGHT: sink_ready <= ($urandom_range(0, 3) != 0);
            SINK_HEAVY: sink_ready <= ($urandom_range(0, 1) != 0);
            default:
            begin
                if (stall_hold != 0)
                    stall_hold <= stall_hold - 1;
                else
                begin
                    sink_ready <= !sink_ready;
                    stall_hold <= $urandom_range(1, 24);
                end
            end
        endcase
    end

    function automatic pkt_item_t make_pkt(input logic [31:0] s_sec, input logic [19:0] s_us,
                                           input logic [31:0] seq, input logic [31:0] r_sec,
                                           input logic [19:0] r_us, input logic [15:0] bytes);
        pkt_item_t p;
        p.send_seconds      = s_sec;
        p.send_microseconds = s_us;
        p.sequence_number   = seq;
        p.recv_seconds      = r_sec;
        p.recv_microseconds = r_us;
        p.byte_count        = bytes;
        return p;
    endfunction

    // Build one random packet. Most follow the stream in order; some skip
    // ahead (small gaps and big jumps), some arrive late or repeat, and the
    // rest are noise with arbitrary timestamps and an old sequence number.
    function automatic pkt_item_t random_pkt();
        int unsigned kind;
        logic [31:0] seq;
        logic [63:0] recv_clock;

        kind = $urandom_range(0, 99);
        if (kind >= 92)
            return make_pkt($urandom, 20'($urandom_range(0, 20'hFFFFF)),
                            $urandom_range(0, front_seq), $urandom,
                            20'($urandom_range(0, 20'hFFFFF)), 16'($urandom));

        if (kind < 70)
            seq = front_seq + 32'd1;
        else if (kind < 80)
            seq = front_seq + $urandom_range(2, 40);
        else if (kind < 84)
            seq = front_seq + $urandom_range(41, 1 << 20);
        else
            seq = $urandom_range((front_seq > 24) ? front_seq - 24 : 0, front_seq);
        if (seq > front_seq)
            front_seq = seq;

        // advance the sender clock; add network delay with occasional spikes
        send_clock = send_clock + 64'($urandom_range(50, 20000));
        recv_clock = send_clock + base_delay + 64'($urandom_range(0, 3000));
        if ($urandom_range(0, 19) == 0)
            recv_clock = recv_clock + 64'($urandom_range(0, 2000000));

        return make_pkt(32'(send_clock / USEC), 20'(send_clock % USEC), seq,
                        32'(recv_clock / USEC), 20'(recv_clock % USEC), 16'($urandom));
    endfunction

    // Present one item and hold it until accepted. Ready is stable between
    // edges, so its value at the falling edge is what the next rising edge sees.
    task automatic push_pkt(input pkt_item_t p);
        packet_ch.valid             <= 1'b1;
        packet_ch.send_seconds      <= p.send_seconds;
        packet_ch.send_microseconds <= p.send_microseconds;
        packet_ch.sequence_number   <= p.sequence_number;
        packet_ch.recv_seconds      <= p.recv_seconds;
        packet_ch.recv_microseconds <= p.recv_microseconds;
        packet_ch.byte_count        <= p.byte_count;
        do
            @(negedge clk);
        while (!packet_ch.ready);
        @(posedge clk);
    endtask

    task automatic idle_for(input int unsigned cycles);
        packet_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drop valid and hold off until the checker has seen every report item.
    task automatic drain();
        packet_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    initial
    begin
        int          sent;
        int          next_stream;
        int unsigned burst;
        int unsigned gap;
        bit          steady;

        packet_ch.valid             = 1'b0;
        packet_ch.send_seconds      = '0;
        packet_ch.send_microseconds = '0;
        packet_ch.sequence_number   = '0;
        packet_ch.recv_seconds      = '0;
        packet_ch.recv_microseconds = '0;
        packet_ch.byte_count        = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: sequence zero after reset does not advance and finds no
        // loss to take back; then in order, a gap, a late packet, a repeat of
        // the highest number.
        push_pkt(make_pkt(32'd0, 20'd0, 32'd0, 32'd0, 20'd0, 16'd0));
        push_pkt(make_pkt(32'd100, 20'd0, 32'd1, 32'd100, 20'd1500, 16'hFFFF));
        push_pkt(make_pkt(32'd100, 20'd20000, 32'd2, 32'd100, 20'd21800, 16'd512));
        push_pkt(make_pkt(32'd100, 20'd40000, 32'd6, 32'd100, 20'd41200, 16'd1024));
        push_pkt(make_pkt(32'd100, 20'd30000, 32'd4, 32'd100, 20'd52000, 16'd64));
        push_pkt(make_pkt(32'd100, 20'd50000, 32'd6, 32'd100, 20'd51000, 16'd64));
        push_pkt(make_pkt(32'd100, 20'd60000, 32'd7, 32'd100, 20'd61300, 16'd1500));
        // microsecond parts of a million and more, used as given
        push_pkt(make_pkt(32'd100, 20'hFFFFF, 32'd8, 32'd101, 20'hF4240, 16'd1500));
        // receive before send: negative transit
        push_pkt(make_pkt(32'd500, 20'd0, 32'd9, 32'd100, 20'd0, 16'd200));
        // transit extremes both ways; the swing drives jitter into saturation
        push_pkt(make_pkt(32'd0, 20'd0, 32'd10, 32'hFFFFFFFF, 20'hFFFFF, 16'd9000));
        push_pkt(make_pkt(32'hFFFFFFFF, 20'hFFFFF, 32'd11, 32'd0, 20'd0, 16'd9000));
        push_pkt(make_pkt(32'd0, 20'd0, 32'd12, 32'hFFFFFFFF, 20'hFFFFF, 16'd9000));
        push_pkt(make_pkt(32'd0, 20'd0, 32'd13, 32'd0, 20'd0, 16'd0));
        push_pkt(make_pkt(32'd200, 20'd999999, 32'd14, 32'd201, 20'd0, 16'd100));
        push_pkt(make_pkt(32'd300, 20'd0, 32'd15, 32'd300, 20'd500, 16'd1400));
        drain();

        // Random: streams of packets in bursts, with a fresh clock base and
        // delay per stream; some streams run with no sender gaps at all.
        front_seq   = 32'd15;
        send_clock  = '0;
        base_delay  = '0;
        steady      = 1'b0;
        sent        = 0;
        next_stream = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= next_stream)
            begin
                send_clock  = 64'($urandom) * USEC + 64'($urandom_range(0, 999999));
                base_delay  = 64'($urandom_range(0, 500000));
                steady      = ($urandom_range(0, 3) == 0);
                next_stream = next_stream + STREAM_LENGTH;
            end
            burst = $urandom_range(1, 16);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++)
            begin
                push_pkt(random_pkt());
                sent++;
            end
            if (!steady)
            begin
                gap = $urandom_range(0, 8);
                if (gap != 0)
                    idle_for(gap);
            end
        end
        drain();

        // Tail: jump far ahead, reach the top sequence number, repeat it, then
        // nothing can advance any more.
        push_pkt(make_pkt(32'd1000, 20'd0, 32'h7FFFFFFF, 32'd1000, 20'd900, 16'hFFFF));
        push_pkt(make_pkt(32'd1000, 20'd1000, 32'hFFFFFFFE, 32'd1000, 20'd1800, 16'hFFFF));
        push_pkt(make_pkt(32'd1000, 20'd2000, 32'hFFFFFFFF, 32'd1000, 20'd2700, 16'hFFFF));
        push_pkt(make_pkt(32'd1000, 20'd3000, 32'hFFFFFFFF, 32'd1000, 20'd3950, 16'hFFFF));
        push_pkt(make_pkt(32'd1000, 20'd4000, 32'd0, 32'd1000, 20'd4100, 16'hFFFF));
        for (int k = 0; k < 4; k++)
            push_pkt(make_pkt($urandom, 20'($urandom_range(0, 999999)), $urandom, $urandom,
                              20'($urandom_range(0, 999999)), 16'($urandom)));
        drain();

        // let any stray report item surface before the verdict
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("udp_seq_loss_jitter_tracker verification clean");
        else
            $display("udp_seq_loss_jitter_tracker verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("udp_seq_loss_jitter_tracker verification failed");
        $finish;
    end

endmodule
